[rtl/core/order_statistic_multiset_assert.svh]
// Assertion macros for the order-statistic multiset RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define OSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define OSM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define OSM_ASSERT(lbl, prop, msg)
`define OSM_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

[rtl/core/osm_pkg.sv]
// Shared types, codes and elaboration helpers for the order-statistic multiset.
// No dependencies; imported by every module of the block.
package osm_pkg;

  localparam int KEY_W        = 32;
  localparam int RANK_W       = 9;
  localparam int DEF_CAPACITY = 256;
  localparam int TREE_FANIN   = 16;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_INSERTED     = 2'd0,
    STAT_ANSWERED     = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2,
    STAT_FULL         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DONE
  } state_t;

  // What one cell hands to the next cell up the row
  typedef struct packed {
    logic                    gt;
    logic signed [KEY_W-1:0] key;
  } link_t;

  // Width of the selected cell index: covers both the rank port and the count
  function automatic int sel_width(int capacity);
    int cw;
    cw = $clog2(capacity + 1);
    return (RANK_W > cw) ? RANK_W : cw;
  endfunction

  // Number of nodes at a level of the selection tree (level 0 is the cells)
  function automatic int tree_nodes(int n, int lvl);
    int m;
    m = n;
    for (int i = 0; i < lvl; i++) begin
      m = (m + TREE_FANIN - 1) / TREE_FANIN;
    end
    return m;
  endfunction

  // Number of registered levels needed to reduce n cells to one node
  function automatic int tree_levels(int n);
    int m;
    int l;
    m = n;
    l = 0;
    for (int i = 0; i < 16; i++) begin
      if (m > 1) begin
        m = (m + TREE_FANIN - 1) / TREE_FANIN;
        l = l + 1;
      end
    end
    return (l < 1) ? 1 : l;
  endfunction

  // Offset of a registered level in the flat node store (level 1 starts at 0)
  function automatic int tree_offset(int n, int lvl);
    int s;
    s = 0;
    for (int k = 1; k < lvl; k++) begin
      s = s + tree_nodes(n, k);
    end
    return s;
  endfunction

endpackage

[rtl/core/osm_cell.sv]
// One sorting cell of the key row: holds one key and shifts on insert.
// Depends on osm_pkg for the key width and the neighbor link type.
module osm_cell import osm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                              clk,
  input  logic                              ins,
  input  logic signed [KEY_W-1:0]           new_key,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  link_t                             prev,
  output link_t                             link
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] key;
  logic                    occ;
  logic                    first_free;
  logic                    gt;

  // Occupancy follows from the fill count; the row stays sorted ascending
  assign occ        = count > CW'(IDX);
  assign first_free = count == CW'(IDX);
  assign gt         = occ && (key > new_key);

  // Shift up when the lower neighbor moves, or take the new key at its slot
  always_ff @(posedge clk) begin
    if (ins) begin
      if (prev.gt) begin
        key <= prev.key;
      end else if (gt || first_free) begin
        key <= new_key;
      end
    end
  end

  assign link.gt  = gt;
  assign link.key = key;

endmodule

[rtl/core/osm_select_tree.sv]
// Registered OR tree that picks the key of one selected cell out of the row.
// Depends on osm_pkg for the fan-in and the level and offset helpers.
module osm_select_tree import osm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic [sel_width(CAPACITY)-1:0]      sel,
  input  logic signed [KEY_W-1:0]             cell_key [CAPACITY],
  output logic signed [KEY_W-1:0]             root
);

  localparam int SEL_W  = sel_width(CAPACITY);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int TOTAL  = tree_offset(CAPACITY, LEVELS + 1);

  logic [KEY_W-1:0] leaf [CAPACITY];
  logic [KEY_W-1:0] node [TOTAL];

  // Mask every cell but the selected one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_leaf
    assign leaf[i] = (sel == SEL_W'(i)) ? cell_key[i] : '0;
  end

  // Reduce groups of children, one register level at a time
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int N    = tree_nodes(CAPACITY, l);
    localparam int NP   = tree_nodes(CAPACITY, l - 1);
    localparam int OFS  = tree_offset(CAPACITY, l);
    localparam int OFSP = tree_offset(CAPACITY, l - 1);
    for (genvar j = 0; j < N; j++) begin : g_node
      localparam int BASE = j * TREE_FANIN;
      localparam int CNT  = (NP - BASE < TREE_FANIN) ? NP - BASE : TREE_FANIN;
      logic [KEY_W-1:0] acc;
      if (l == 1) begin : g_first
        always_comb begin
          acc = '0;
          for (int c = 0; c < CNT; c++) begin
            acc = acc | leaf[BASE + c];
          end
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int c = 0; c < CNT; c++) begin
            acc = acc | node[OFSP + BASE + c];
          end
        end
      end
      always_ff @(posedge clk) begin
        node[OFS + j] <= acc;
      end
    end
  end

  assign root = node[TOTAL - 1];

endmodule

[rtl/core/order_statistic_multiset.sv]
// Channel | signals                               | transaction
// --------+---------------------------------------+-------------------------------
// input   | in_valid, in_ready, kind, new_key, rank | one insert or one rank query
// output  | out_valid, out_ready, status, found_key | one result per input item
//
// An insert reaches the output register through the done state: the cell row shifts as
// the insert is accepted. A query out of range takes the same path. An answered query
// first stays in the wait state while its key climbs the LEVELS registered levels of the
// 16-way selection tree (1 up to 16 entries, 2 for 256 entries, 3 up to 4096).
// One item is in flight at a time; a new item is taken while a result waits.
// Synchronous active-high reset empties the store at once, with no clearing pass.
// A stalled output holds the finished item in the done state until taken.
module order_statistic_multiset import osm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic [RANK_W-1:0]       rank,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [KEY_W-1:0] found_key
);

`include "order_statistic_multiset_assert.svh"

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int SEL_W  = sel_width(CAPACITY);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int LVL_W  = $clog2(LEVELS + 1);

  state_t                  state;
  state_t                  state_next;
  logic [CW-1:0]           count;
  logic [LVL_W-1:0]        wait_cnt;
  logic [SEL_W-1:0]        sel;
  status_t                 res_status;
  status_t                 res_status_next;
  logic                    in_acc;
  logic                    move;
  logic                    full;
  logic                    in_range;
  logic                    ins;
  logic [SEL_W-1:0]        rank_ext;
  link_t                   link [CAPACITY];
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic signed [KEY_W-1:0] root;

  // Classify the incoming transaction
  assign rank_ext = SEL_W'(rank);
  assign full     = count == CW'(CAPACITY);
  assign in_range = (rank != '0) && (rank_ext <= SEL_W'(count));
  assign in_acc   = in_valid && in_ready;
  assign ins      = in_acc && (kind == KIND_INSERT) && !full;

  always_comb begin
    if (kind == KIND_INSERT) begin
      res_status_next = full ? STAT_FULL : STAT_INSERTED;
    end else begin
      res_status_next = in_range ? STAT_ANSWERED : STAT_OUT_OF_RANGE;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (kind == KIND_QUERY && in_range) ? S_WAIT : S_DONE;
        end
      end
      S_WAIT: begin
        if (wait_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (move) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready = 1'b0;
    move     = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_WAIT:  move     = 1'b0;
      S_DONE:  move     = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ins) begin
        count <= count + CW'(1);
      end
    end
  end

  // Hold the transaction's result code, selected index and tree delay
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status <= res_status_next;
      sel        <= rank_ext - SEL_W'(1);
      wait_cnt   <= LVL_W'(LEVELS - 1);
    end else if (state == S_WAIT) begin
      wait_cnt <= wait_cnt - LVL_W'(1);
    end
  end

  // Row of sorting cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = link[i-1];
    end
    osm_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk     (clk),
      .ins     (ins),
      .new_key (new_key),
      .count   (count),
      .prev    (prev),
      .link    (link[i])
    );
    assign cell_key[i] = link[i].key;
  end

  osm_select_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk      (clk),
    .sel      (sel),
    .cell_key (cell_key),
    .root     (root)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status    <= res_status;
      found_key <= (res_status == STAT_ANSWERED) ? root : '0;
    end
  end

  `OSM_ASSERT(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `OSM_ASSERT_NEXT(a_insert_grows, ins, count == $past(count) + CW'(1), "insert lost")
  `OSM_ASSERT_NEXT(a_query_keeps, in_acc && kind == KIND_QUERY, $stable(count), "query moved count")
  `OSM_ASSERT(a_zero_key, (out_valid && status != STAT_ANSWERED) |-> (found_key == '0), "key not zeroed")

endmodule

[tb/osm_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the order-statistic multiset: keeps a sorted shadow of the keys,
// predicts one result per input transaction and compares every output transaction.
// Depends on osm_pkg for field widths and the kind and status codes.
module osm_result_checker import osm_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic [RANK_W-1:0]       rank,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              status,
  input  logic signed [KEY_W-1:0] found_key,
  output int                      fault_count,
  output int                      open_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] key;
  } outcome_t;

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int                      shadow_count = 0;
  outcome_t                awaited [$];
  outcome_t                oldest;
  int                      faults = 0;
  int                      open_items = 0;

  assign fault_count = faults;
  assign open_count  = open_items;

  // Apply one transaction to the shadow store and return the result it must produce
  function automatic outcome_t apply_item(kind_t op, logic signed [KEY_W-1:0] key,
                                          logic [RANK_W-1:0] want_rank);
    outcome_t res;
    int       pos;
    res.status = STAT_INSERTED;
    res.key    = '0;
    if (op == KIND_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        // shift larger keys up one slot, equal keys stay below the new one
        pos = shadow_count;
        while (pos > 0 && shadow_keys[pos-1] > key) begin
          shadow_keys[pos] = shadow_keys[pos-1];
          pos--;
        end
        shadow_keys[pos] = key;
        shadow_count++;
      end
    end else if (want_rank == 0 || want_rank > shadow_count) begin
      res.status = STAT_OUT_OF_RANGE;
    end else begin
      res.status = STAT_ANSWERED;
      res.key    = shadow_keys[want_rank-1];
    end
    return res;
  endfunction

  task automatic record_fault(input string detail);
    faults++;
    if (faults <= REPORT_LIMIT) begin
      $display("%0t: result mismatch: %s", $time, detail);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      awaited.delete();
    end else begin
      // Retire the oldest prediction against each output transaction
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          record_fault($sformatf("no transaction outstanding, got status %0d key %0d",
                                 status, found_key));
        end else begin
          oldest = awaited.pop_front();
          if (status !== oldest.status || found_key !== oldest.key) begin
            record_fault($sformatf("expected status %0d key %0d, got status %0d key %0d",
                                   oldest.status, oldest.key, status, found_key));
          end
        end
      end
      // Predict the result of each input transaction
      if (in_valid && in_ready) begin
        awaited.push_back(apply_item(kind_t'(kind), new_key, rank));
      end
    end
    open_items = awaited.size();
  end

endmodule

[tb/tb_order_statistic_multiset.sv]
`timescale 1ns / 1ps
// Top of the order-statistic multiset testbench: clock, reset, stimulus and verdict.
// Drives inserts and rank queries with random gaps and stalls; osm_result_checker
// predicts and compares. Depends on osm_pkg, order_statistic_multiset and the checker.
module tb_order_statistic_multiset;
  import osm_pkg::*;

  localparam int CAPACITY        = DEF_CAPACITY;
  localparam int RANDOM_ITEMS    = 1880;
  localparam int MODE_SPAN       = 128;
  localparam int HOLD_OFF_AT     = 600;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 16;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = KIND_INSERT;
  logic signed [KEY_W-1:0] new_key = '0;
  logic [RANK_W-1:0]       rank = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic signed [KEY_W-1:0] found_key;

  int keys_held = 0;
  int results_taken = 0;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  always #5 clk = ~clk;

  order_statistic_multiset #(.CAPACITY(CAPACITY)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .new_key   (new_key),
    .rank      (rank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found_key (found_key)
  );

  osm_result_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .new_key     (new_key),
    .rank        (rank),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_key   (found_key),
    .fault_count (mismatches),
    .open_count  (outstanding)
  );

  // Offer one transaction after a random gap and hold it until accepted
  task automatic offer(input kind_t op, input logic signed [KEY_W-1:0] key,
                       input logic [RANK_W-1:0] want_rank);
    int gap;
    gap = send_burst ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    new_key  <= key;
    rank     <= want_rank;
    do @(posedge clk); while (!in_ready);
    if (op == KIND_INSERT && keys_held < CAPACITY) keys_held++;
  endtask

  // Mix wide random keys with clustered duplicates and values at the extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] key;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: key = $urandom;
      4, 5, 6:    key = $signed($urandom_range(16, 0)) - 8;
      7: begin
        case ($urandom_range(3, 0))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = '0;
          default: key = -1;
        endcase
      end
      8:       key = KEY_MIN + $urandom_range(15, 0);
      default: key = KEY_MAX - $urandom_range(15, 0);
    endcase
    return key;
  endfunction

  // Aim most ranks inside the held range, the rest at its edges and beyond
  function automatic logic [RANK_W-1:0] pick_rank();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 65 && keys_held > 0) return RANK_W'($urandom_range(keys_held, 1));
    if (sel < 75) return RANK_W'(keys_held + 1);
    if (sel < 80) return '0;
    if (sel < 88) return RANK_W'($urandom_range(CAPACITY + 1, CAPACITY - 1));
    return RANK_W'($urandom_range(511, 0));
  endfunction

  // End the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("order_statistic_multiset regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Take results with random stalls; hold off once for long so the block backs up
  initial begin : receiver
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken % MODE_SPAN == 0) take_burst = ($urandom_range(3, 0) == 0);
      hold = take_burst ? 0 : $urandom_range(15, 0);
      if (results_taken == HOLD_OFF_AT) hold = HOLD_OFF_CYCLES;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Query the empty store, including rank zero and an all-ones rank
    offer(KIND_QUERY, '0, '0);
    offer(KIND_QUERY, -1, 1);
    offer(KIND_QUERY, '0, '1);
    // Insert the extremes, zero, minus one, a duplicate pair and one
    offer(KIND_INSERT, KEY_MAX, '1);
    offer(KIND_INSERT, KEY_MIN, '0);
    offer(KIND_INSERT, '0, '0);
    offer(KIND_INSERT, -1, '0);
    offer(KIND_INSERT, 5, '0);
    offer(KIND_INSERT, 5, 1);
    offer(KIND_INSERT, 1, '0);
    // Walk the ranks: zero, bottom, middle, the duplicates, top, just above and the capacity
    offer(KIND_QUERY, -1, '0);
    offer(KIND_QUERY, '0, 1);
    offer(KIND_QUERY, '0, 3);
    offer(KIND_QUERY, '0, 5);
    offer(KIND_QUERY, '0, 6);
    offer(KIND_QUERY, KEY_MAX, 7);
    offer(KIND_QUERY, '0, 8);
    offer(KIND_QUERY, '0, RANK_W'(CAPACITY));
    // Duplicate the minimum and read both copies
    offer(KIND_INSERT, KEY_MIN, '0);
    offer(KIND_QUERY, '0, 1);
    offer(KIND_QUERY, '0, 2);

    // Random mix; the store fills partway through, then inserts are dropped
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % MODE_SPAN == 0) send_burst = ($urandom_range(3, 0) == 0);
      if ($urandom_range(99, 0) < 30) begin
        offer(KIND_INSERT, pick_key(), RANK_W'($urandom_range(511, 0)));
      end else begin
        offer(KIND_QUERY, $urandom, pick_rank());
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for a stray one
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("order_statistic_multiset regression: pass");
    end else begin
      $display("order_statistic_multiset regression: fail");
    end
    $finish;
  end

endmodule
